/* rtl/core/assert_macros.svh */
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Assertion helpers; the enclosing module supplies clk and rst_n.

// Condition holds at every clock edge out of reset
`define CSR_ASSERT(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// Implication in the same cycle
`define CSR_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

`endif

/* rtl/core/csr_pkg.sv */
`default_nettype none
package csr_pkg;

  // Fixed point format of the stream
  localparam int FRAC_BITS = 16;
  localparam int DATA_W    = 32;

  // Square root units: 64-bit radicand, 32-bit root, two radicand bits a stage
  localparam int RAD_W     = 2 * DATA_W;
  localparam int ROOT_W    = DATA_W;
  localparam int REM_W     = ROOT_W + 2;
  localparam int SQ_STAGES = ROOT_W;

  // Sum |x| + m before the second root
  localparam int SUM_W     = DATA_W + 1;

  // Divider: (|y| << FRAC_BITS) / (2w), one quotient bit a stage
  localparam int DVD_W     = DATA_W + FRAC_BITS;
  localparam int DVS_W     = ROOT_W + 1;
  localparam int DIV_STAGES = DVD_W;

  // Sideband that travels with each word through the pipeline
  typedef struct packed {
    logic [DATA_W-1:0] ax;    // |x|
    logic [DATA_W-1:0] ay;    // |y|
    logic              xneg;
    logic              yneg;
    logic              zero;  // both parts zero
    logic [DATA_W-1:0] mid;   // m after the first root, w after the second
  } side_t;

endpackage
`default_nettype wire

/* rtl/core/csr_isqrt.sv */
`default_nettype none
`include "assert_macros.svh"
// Pipelined integer square root, one root bit per stage (restoring method)
module csr_isqrt (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        en,
  input  logic                        in_vld,
  input  logic [csr_pkg::RAD_W-1:0]   in_rad,
  input  csr_pkg::side_t              in_side,
  output logic                        out_vld,
  output logic [csr_pkg::ROOT_W-1:0]  out_root,
  output csr_pkg::side_t              out_side
);
  import csr_pkg::*;

  localparam int LAST = SQ_STAGES - 1;

  logic              vld_r  [SQ_STAGES];
  logic [RAD_W-1:0]  rad_r  [SQ_STAGES];
  logic [REM_W-1:0]  rem_r  [SQ_STAGES];
  logic [ROOT_W-1:0] root_r [SQ_STAGES];
  side_t             side_r [SQ_STAGES];

  for (genvar i = 0; i < SQ_STAGES; i++) begin : g_st
    logic              src_vld;
    logic [RAD_W-1:0]  src_rad;
    logic [REM_W-1:0]  src_rem;
    logic [ROOT_W-1:0] src_root;
    side_t             src_side;
    logic [REM_W+1:0]  cur;
    logic [REM_W+1:0]  trial;
    logic [REM_W-1:0]  rem_nxt;
    logic [ROOT_W-1:0] root_nxt;

    if (i == 0) begin : g_first
      assign src_vld  = in_vld;
      assign src_rad  = in_rad;
      assign src_rem  = '0;
      assign src_root = '0;
      assign src_side = in_side;
    end else begin : g_next
      assign src_vld  = vld_r[i-1];
      assign src_rad  = rad_r[i-1];
      assign src_rem  = rem_r[i-1];
      assign src_root = root_r[i-1];
      assign src_side = side_r[i-1];
    end

    // bring down two radicand bits and try root*4+1
    always_comb begin
      cur   = {src_rem, src_rad[RAD_W-1 -: 2]};
      trial = {2'b00, src_root, 2'b01};
      if (cur >= trial) begin
        rem_nxt  = REM_W'(cur - trial);
        root_nxt = {src_root[ROOT_W-2:0], 1'b1};
      end else begin
        rem_nxt  = REM_W'(cur);
        root_nxt = {src_root[ROOT_W-2:0], 1'b0};
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[i] <= 1'b0;
      end else if (en) begin
        vld_r[i]  <= src_vld;
        rad_r[i]  <= {src_rad[RAD_W-3:0], 2'b00};
        rem_r[i]  <= rem_nxt;
        root_r[i] <= root_nxt;
        side_r[i] <= src_side;
      end
    end
  end

  assign out_vld  = vld_r[LAST];
  assign out_root = root_r[LAST];
  assign out_side = side_r[LAST];

  // remainder of a finished root never exceeds twice the root
  logic [REM_W-1:0] root_x2;
  assign root_x2 = {1'b0, root_r[LAST], 1'b0};

  `CSR_ASSERT_IMP(a_sq_rem_bound, vld_r[LAST], rem_r[LAST] <= root_x2, "isqrt remainder too big")

endmodule
`default_nettype wire

/* rtl/core/csr_div.sv */
`default_nettype none
`include "assert_macros.svh"
// Pipelined restoring divider, one quotient bit per stage
module csr_div (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       en,
  input  logic                       in_vld,
  input  logic [csr_pkg::DVD_W-1:0]  in_dvd,
  input  logic [csr_pkg::DVS_W-1:0]  in_dvs,
  input  csr_pkg::side_t             in_side,
  output logic                       out_vld,
  output logic [csr_pkg::DVD_W-1:0]  out_quo,
  output csr_pkg::side_t             out_side
);
  import csr_pkg::*;

  localparam int LAST = DIV_STAGES - 1;

  logic             vld_r [DIV_STAGES];
  logic [DVD_W-1:0] dvd_r [DIV_STAGES];
  logic [DVS_W-1:0] dvs_r [DIV_STAGES];
  logic [DVS_W-1:0] rem_r [DIV_STAGES];
  logic [DVD_W-1:0] quo_r [DIV_STAGES];
  side_t            side_r [DIV_STAGES];

  for (genvar i = 0; i < DIV_STAGES; i++) begin : g_st
    logic             src_vld;
    logic [DVD_W-1:0] src_dvd;
    logic [DVS_W-1:0] src_dvs;
    logic [DVS_W-1:0] src_rem;
    logic [DVD_W-1:0] src_quo;
    side_t            src_side;
    logic [DVS_W:0]   cur;
    logic [DVS_W-1:0] rem_nxt;
    logic             bit_nxt;

    if (i == 0) begin : g_first
      assign src_vld  = in_vld;
      assign src_dvd  = in_dvd;
      assign src_dvs  = in_dvs;
      assign src_rem  = '0;
      assign src_quo  = '0;
      assign src_side = in_side;
    end else begin : g_next
      assign src_vld  = vld_r[i-1];
      assign src_dvd  = dvd_r[i-1];
      assign src_dvs  = dvs_r[i-1];
      assign src_rem  = rem_r[i-1];
      assign src_quo  = quo_r[i-1];
      assign src_side = side_r[i-1];
    end

    // shift in the next dividend bit and subtract if it fits
    always_comb begin
      cur = {src_rem, src_dvd[DVD_W-1]};
      if (cur >= {1'b0, src_dvs}) begin
        rem_nxt = DVS_W'(cur - {1'b0, src_dvs});
        bit_nxt = 1'b1;
      end else begin
        rem_nxt = DVS_W'(cur);
        bit_nxt = 1'b0;
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[i] <= 1'b0;
      end else if (en) begin
        vld_r[i]  <= src_vld;
        dvd_r[i]  <= {src_dvd[DVD_W-2:0], 1'b0};
        dvs_r[i]  <= src_dvs;
        rem_r[i]  <= rem_nxt;
        quo_r[i]  <= {src_quo[DVD_W-2:0], bit_nxt};
        side_r[i] <= src_side;
      end
    end
  end

  assign out_vld  = vld_r[LAST];
  assign out_quo  = quo_r[LAST];
  assign out_side = side_r[LAST];

  `CSR_ASSERT_IMP(a_div_rem_bound, vld_r[LAST], rem_r[LAST] < dvs_r[LAST], "div rem too big")

endmodule
`default_nettype wire

/* rtl/core/complex_square_root_unit.sv */
// Complex principal square root of a signed Q16.16 sample (x + iy), one word in
// and one word out. A new word is taken every cycle while the output is not stalled;
// each word passes the stages: magnitude and squares (3), the magnitude root (32,
// one bit a stage), a sum stage (1), the second root (32), the quotient y/(2w)
// (48, one bit a stage) and the output register (1). The whole pipeline advances
// when the output register is empty or being taken, so back-pressure stalls every
// stage together and nothing is lost. The result has a non-negative real part; on
// the negative real axis the imaginary part is non-negative. Quotients truncate
// toward zero and saturate to 32 bits; a zero input gives zero.
`default_nettype none
`include "assert_macros.svh"
module complex_square_root_unit (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [63:0] in_tdata,   // [31:0] real_in, [63:32] imag_in
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [63:0] out_tdata   // [31:0] real_out, [63:32] imag_out
);
  import csr_pkg::*;

  logic en;
  assign en        = !out_tvalid || out_tready;
  assign in_tready = en;

  // stage A: magnitudes and signs
  logic [DATA_W-1:0] x_in, y_in;
  side_t             a_side_nxt, a_side_r;
  logic              a_vld_r;

  assign x_in = in_tdata[DATA_W-1:0];
  assign y_in = in_tdata[2*DATA_W-1:DATA_W];

  always_comb begin
    a_side_nxt.xneg = x_in[DATA_W-1];
    a_side_nxt.yneg = y_in[DATA_W-1];
    a_side_nxt.ax   = x_in[DATA_W-1] ? (~x_in + 1'b1) : x_in;
    a_side_nxt.ay   = y_in[DATA_W-1] ? (~y_in + 1'b1) : y_in;
    a_side_nxt.zero = (x_in == '0) && (y_in == '0);
    a_side_nxt.mid  = '0;
  end

  // stage B: squares
  logic [RAD_W-1:0] sqx_r, sqy_r;
  side_t            b_side_r;
  logic             b_vld_r;

  // stage C: sum of squares
  logic [RAD_W-1:0] sum_r;
  side_t            c_side_r;
  logic             c_vld_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_vld_r <= 1'b0;
      b_vld_r <= 1'b0;
      c_vld_r <= 1'b0;
    end else if (en) begin
      a_vld_r  <= in_tvalid;
      a_side_r <= a_side_nxt;
      b_vld_r  <= a_vld_r;
      b_side_r <= a_side_r;
      sqx_r    <= RAD_W'(a_side_r.ax) * RAD_W'(a_side_r.ax);
      sqy_r    <= RAD_W'(a_side_r.ay) * RAD_W'(a_side_r.ay);
      c_vld_r  <= b_vld_r;
      c_side_r <= b_side_r;
      sum_r    <= sqx_r + sqy_r;
    end
  end

  // magnitude m = isqrt(x^2 + y^2)
  logic              m_vld;
  logic [ROOT_W-1:0] m_root;
  side_t             m_side;

  csr_isqrt u_mag_sqrt (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (en),
    .in_vld   (c_vld_r),
    .in_rad   (sum_r),
    .in_side  (c_side_r),
    .out_vld  (m_vld),
    .out_root (m_root),
    .out_side (m_side)
  );

  // stage D: (|x| + m) << (FRAC_BITS-1)
  logic [SUM_W-1:0] sum_am;
  logic [RAD_W-1:0] d_rad_r;
  side_t            d_side_nxt;
  side_t            d_side_r;
  logic             d_vld_r;

  assign sum_am = {1'b0, m_side.ax} + {1'b0, m_root};

  always_comb begin
    d_side_nxt     = m_side;
    d_side_nxt.mid = m_root;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      d_vld_r <= 1'b0;
    end else if (en) begin
      d_vld_r  <= m_vld;
      d_rad_r  <= {{(RAD_W-SUM_W){1'b0}}, sum_am} << (FRAC_BITS - 1);
      d_side_r <= d_side_nxt;
    end
  end

  // w = isqrt((|x| + m) << (FRAC_BITS-1))
  logic              w_vld;
  logic [ROOT_W-1:0] w_root;
  side_t             w_side;
  side_t             w_side_fwd;
  logic [DVD_W-1:0]  dvd;
  logic [DVS_W-1:0]  dvs;

  csr_isqrt u_half_sqrt (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (en),
    .in_vld   (d_vld_r),
    .in_rad   (d_rad_r),
    .in_side  (d_side_r),
    .out_vld  (w_vld),
    .out_root (w_root),
    .out_side (w_side)
  );

  // divisor 2w; a zero word divides by one, its result is forced to zero later
  always_comb begin
    w_side_fwd     = w_side;
    w_side_fwd.mid = w_root;
    dvd            = {w_side.ay, {FRAC_BITS{1'b0}}};
    dvs            = w_side.zero ? DVS_W'(1) : {w_root, 1'b0};
  end

  logic             q_vld;
  logic [DVD_W-1:0] q_quo;
  side_t            q_side;

  csr_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (en),
    .in_vld   (w_vld),
    .in_dvd   (dvd),
    .in_dvs   (dvs),
    .in_side  (w_side_fwd),
    .out_vld  (q_vld),
    .out_quo  (q_quo),
    .out_side (q_side)
  );

  // output stage: sign placement and saturation
  logic              q_big;
  logic [DATA_W-1:0] q_pos, q_neg, w_pos, w_neg;
  logic [DATA_W-1:0] re_nxt, im_nxt;
  logic [DATA_W-1:0] re_r, im_r;
  logic              out_vld_r;

  always_comb begin
    q_big = (q_quo[DVD_W-1:DATA_W-1] != '0);
    q_pos = q_big ? {1'b0, {(DATA_W-1){1'b1}}} : q_quo[DATA_W-1:0];
    q_neg = q_big ? {1'b1, {(DATA_W-1){1'b0}}} : (~q_quo[DATA_W-1:0] + 1'b1);
    w_pos = q_side.mid;
    w_neg = ~q_side.mid + 1'b1;
    if (q_side.zero) begin
      re_nxt = '0;
      im_nxt = '0;
    end else if (!q_side.xneg) begin
      re_nxt = w_pos;
      im_nxt = q_side.yneg ? q_neg : q_pos;
    end else begin
      re_nxt = q_pos;
      im_nxt = q_side.yneg ? w_neg : w_pos;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (en) begin
      out_vld_r <= q_vld;
      re_r      <= re_nxt;
      im_r      <= im_nxt;
    end
  end

  assign out_tvalid = out_vld_r;
  assign out_tdata  = {im_r, re_r};

  // principal root: real part never negative
  `CSR_ASSERT_IMP(a_real_nonneg, out_vld_r, !re_r[DATA_W-1], "negative real part on output")
  // a stalled output word keeps the pipeline frozen
  `CSR_ASSERT_IMP(a_stall_freeze, out_vld_r && !out_tready, !in_tready, "input taken during stall")

endmodule
`default_nettype wire

/* bench/complex_square_root_unit_tb.sv */
`default_nettype none

// Expected results of the complex square root, held in order of arrival
class csqrt_scoreboard;
  logic [63:0] root_q[$];
  int unsigned errors;

  function new();
    errors = 0;
  endfunction

  // Integer square root, floor, of a 64-bit value
  static function automatic logic [63:0] isqrt(logic [63:0] v);
    logic [63:0] res;
    logic [63:0] bitv;
    res = 0;
    bitv = 64'd1 << 62;
    while (bitv > v) bitv = bitv >> 2;
    while (bitv != 0) begin
      if (v >= res + bitv) begin
        v = v - (res + bitv);
        res = (res >> 1) + bitv;
      end else begin
        res = res >> 1;
      end
      bitv = bitv >> 2;
    end
    return res;
  endfunction

  // Principal root of x + iy in Q16.16
  static function automatic logic [63:0] principal_root(logic [63:0] word);
    logic [31:0] xr, yr, re, im;
    logic [63:0] ax, ay, m, w, q;
    logic        xneg, yneg;
    xr = word[31:0];
    yr = word[63:32];
    xneg = xr[31];
    yneg = yr[31];
    ax = xneg ? (64'h1_0000_0000 - {32'd0, xr}) : {32'd0, xr};
    ay = yneg ? (64'h1_0000_0000 - {32'd0, yr}) : {32'd0, yr};
    if (ax == 0 && ay == 0) return 64'd0;
    m = isqrt(ax * ax + ay * ay);
    w = isqrt((ax + m) << (csr_pkg::FRAC_BITS - 1));
    q = (ay << csr_pkg::FRAC_BITS) / (2 * w);
    if (!xneg) begin
      re = w[31:0];
      if (yneg) im = (q >= 64'h8000_0000) ? 32'h8000_0000 : 32'(-q);
      else im = (q > 64'h7FFF_FFFF) ? 32'h7FFF_FFFF : q[31:0];
    end else begin
      re = (q > 64'h7FFF_FFFF) ? 32'h7FFF_FFFF : q[31:0];
      im = yneg ? 32'(-w) : w[31:0];
    end
    return {im, re};
  endfunction

  function void note_sample(logic [63:0] word);
    root_q.push_back(principal_root(word));
  endfunction

  function void check_root(logic [63:0] got);
    logic [63:0] exp;
    if (root_q.size() == 0) begin
      $display("%0t: unexpected word %h", $time, got);
      errors++;
      return;
    end
    exp = root_q.pop_front();
    if (got[31:0] !== exp[31:0]) begin
      $display("%0t: real_out expected %h actual %h", $time, exp[31:0], got[31:0]);
      errors++;
    end
    if (got[63:32] !== exp[63:32]) begin
      $display("%0t: imag_out expected %h actual %h", $time, exp[63:32], got[63:32]);
      errors++;
    end
  endfunction
endclass

module complex_square_root_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int LATENCY = 117;
  localparam int RANDOM_WORDS = 1700;
  localparam longint CYCLE_LIMIT = 400000;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [63:0] in_tdata = '0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [63:0] out_tdata;

  csqrt_scoreboard sb = new();
  longint cycles = 0;
  bit     sending_done = 1'b0;

  always #1 clk = ~clk;

  complex_square_root_unit dut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata)
  );

  // Timeout watchdog
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("complex_square_root_unit_tb: FAIL");
      $finish;
    end
  end

  // Result side: check accepted words, random stalls
  initial begin
    int gap;
    repeat (6) @(posedge clk);
    forever begin
      @(posedge clk);
      if (out_tvalid && out_tready) begin
        sb.check_root(out_tdata);
        gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 13);
        if (gap != 0) out_tready <= 1'b0;
      end else if (!out_tready) begin
        if (gap > 0) gap--;
        if (gap == 0) out_tready <= 1'b1;
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  // Send one word, with a random gap first unless burst mode
  task automatic send_word(logic [31:0] re, logic [31:0] im, bit burst);
    int gap;
    gap = burst ? 0 : $urandom_range(0, 13);
    if (gap != 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= {im, re};
    do @(posedge clk); while (!in_tready);
    sb.note_sample({im, re});
  endtask

  function automatic logic [31:0] rand_part();
    case ($urandom_range(0, 5))
      0: return $urandom_range(0, 3) << $urandom_range(0, 30);
      1: return -($urandom_range(0, 3) << $urandom_range(0, 30));
      2: return $urandom_range(0, 255) - 128;
      3: return {$urandom_range(0, 1) ? 16'hFFFF : 16'h0000, 16'($urandom())};
      default: return $urandom();
    endcase
  endfunction

  initial begin
    logic [31:0] edge_vals[8];
    int n;
    edge_vals = '{32'h0, 32'h1, 32'hFFFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000,
                  32'h0001_0000, 32'hFFFF_0000, 32'h8000_0001};
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    // Directed: zero, axes, extreme corners, saturating quotients
    for (int i = 0; i < 5; i++)
      for (int j = 0; j < 5; j++)
        send_word(edge_vals[(i * 3) % 8], edge_vals[(j * 5 + i) % 8], 1'b0);
    send_word(32'h8000_0000, 32'h0000_0001, 1'b0);
    send_word(32'h8000_0000, 32'hFFFF_FFFF, 1'b0);
    // Hold off until the pipeline drains
    in_tvalid <= 1'b0;
    while (sb.root_q.size() != 0) @(posedge clk);
    // Random words, some in back-to-back bursts
    n = 0;
    while (n < RANDOM_WORDS) begin
      bit burst;
      int len;
      burst = $urandom_range(0, 3) == 0;
      len = $urandom_range(1, 40);
      for (int k = 0; k < len; k++) begin
        send_word(rand_part(), rand_part(), burst);
        n++;
      end
    end
    in_tvalid <= 1'b0;
    while (sb.root_q.size() != 0) @(posedge clk);
    repeat (LATENCY + 20) @(posedge clk);
    if (sb.errors == 0) begin
      $display("complex_square_root_unit_tb: PASS");
    end else begin
      $display("complex_square_root_unit_tb: FAIL");
    end
    $finish;
  end
endmodule

`default_nettype wire
